FILE: rtl/core/bdlpr_pkg.sv
package bdlpr_pkg;

  // Button count and register layout are fixed here
  localparam int NUM_BUTTONS = 3;
  localparam int COUNT_W     = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_TICKS     = 1'd1;

  localparam logic [COUNT_W-1:0] LONG_PRESS_TICKS_RESET = 16'd100;
  localparam logic [COUNT_W-1:0] REPEAT_TICKS_RESET     = 16'd10;

  typedef struct packed {
    logic [COUNT_W-1:0] long_press_ticks;
    logic [COUNT_W-1:0] repeat_ticks;
  } bdlpr_cfg_t;

  typedef struct packed {
    logic pressed;
    logic long_press;
    logic held;
  } bdlpr_flags_t;

endpackage

FILE: rtl/core/button_debounce_long_press_repeat_unit.sv
// A request accepted into the input register passes through the result register to out_valid.
// Throughput: one request per cycle; the input register and result register
// each take a new request whenever the stage ahead of it moves or is empty.
// The rate is set by the combinational per-button update between the two registers.
// Reset (rst, synchronous): all buttons released, counters and flags cleared,
// long_press_ticks = 100, repeat_ticks = 10, both stages empty.
module button_debounce_long_press_repeat_unit
  import bdlpr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [NUM_BUTTONS-1:0] raw_levels,
  input  logic [NUM_BUTTONS-1:0] clear_held_mask,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [NUM_BUTTONS-1:0] pressed_mask,
  output logic [NUM_BUTTONS-1:0] long_press_mask,
  output logic [NUM_BUTTONS-1:0] held_mask
);

  bdlpr_cfg_t             cfg;
  logic                   in_q_valid;
  logic [NUM_BUTTONS-1:0] raw_q;
  logic [NUM_BUTTONS-1:0] clr_q;
  logic                   advance;
  bdlpr_flags_t           flags_next [NUM_BUTTONS];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks <= LONG_PRESS_TICKS_RESET;
      cfg.repeat_ticks     <= REPEAT_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data;
        REG_REPEAT_TICKS:     cfg.repeat_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Move the held request into the buttons when the result slot frees up
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      raw_q <= raw_levels;
      clr_q <= clear_held_mask;
    end
  end

  // One lane per button
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_button
    bdlpr_button u_button (
      .clk        (clk),
      .rst        (rst),
      .en         (advance),
      .sample     (raw_q[i]),
      .clr_held   (clr_q[i]),
      .cfg        (cfg),
      .flags_next (flags_next[i])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_result
    always_ff @(posedge clk) begin
      if (advance) begin
        pressed_mask[i]    <= flags_next[i].pressed;
        long_press_mask[i] <= flags_next[i].long_press;
        held_mask[i]       <= flags_next[i].held;
      end
    end
  end

`ifndef SYNTH
  // A held flag only exists on a long press
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((held_mask & ~long_press_mask) == '0))
    else $error("held flag without long press");

  // A long press only exists while debounced pressed
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((long_press_mask & ~pressed_mask) == '0))
    else $error("long press flag without press");

  // Input stalls only when the result slot is full and blocked
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_q_valid && out_valid && out_stall))
    else $error("input stalled with free result slot");

  // A blocked result is not overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(held_mask)
                                  && $stable(pressed_mask)))
    else $error("stalled result changed");
`endif

endmodule

FILE: rtl/core/bdlpr_button.sv
module bdlpr_button
  import bdlpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         sample,
  input  logic         clr_held,
  input  bdlpr_cfg_t   cfg,
  output bdlpr_flags_t flags_next
);

  // Two newest samples; the oldest of the three is dropped each tick
  logic [1:0]         hist;
  logic               stable;
  logic [COUNT_W-1:0] press_count;
  logic [COUNT_W-1:0] repeat_count;
  logic               long_flag;
  logic               held_flag;

  logic               stable_next;
  logic [COUNT_W-1:0] press_count_next;
  logic [COUNT_W-1:0] repeat_count_next;
  logic [COUNT_W-1:0] repeat_inc;
  logic               long_flag_next;
  logic               held_flag_next;

  // Debounce, then advance press and repeat counters while pressed; clear them on release
  always_comb begin
    repeat_inc        = repeat_count + 1'b1;
    stable_next       = stable;
    press_count_next  = press_count;
    repeat_count_next = repeat_count;
    long_flag_next    = long_flag;
    held_flag_next    = held_flag & ~clr_held;
    if (hist[1] == hist[0] && hist[0] == sample) begin
      stable_next = sample;
    end
    if (!stable_next) begin
      if (press_count < cfg.long_press_ticks) begin
        press_count_next = press_count + 1'b1;
      end else begin
        long_flag_next = 1'b1;
        if (repeat_count < cfg.repeat_ticks) begin
          repeat_count_next = repeat_inc;
          if (repeat_inc == cfg.repeat_ticks) begin
            held_flag_next    = 1'b1;
            repeat_count_next = '0;
          end
        end
      end
    end else begin
      press_count_next  = '0;
      repeat_count_next = '0;
      long_flag_next    = 1'b0;
      held_flag_next    = 1'b0;
    end
  end

  assign flags_next.pressed    = ~stable_next;
  assign flags_next.long_press = long_flag_next;
  assign flags_next.held       = held_flag_next;

  // Commit state on each tick request
  always_ff @(posedge clk) begin
    if (rst) begin
      hist         <= 2'b11;
      stable       <= 1'b1;
      press_count  <= '0;
      repeat_count <= '0;
      long_flag    <= 1'b0;
      held_flag    <= 1'b0;
    end else if (en) begin
      hist         <= {hist[0], sample};
      stable       <= stable_next;
      press_count  <= press_count_next;
      repeat_count <= repeat_count_next;
      long_flag    <= long_flag_next;
      held_flag    <= held_flag_next;
    end
  end

endmodule
